@@ hdl/trr_pkg.sv @@
package trr_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RES_DEPTH   = STORE_DEPTH + 1;
  localparam int RIDX_W      = $clog2(RES_DEPTH);
  localparam int RCNT_W      = $clog2(RES_DEPTH + 1);

  localparam logic [29:0] WIN_MAX = 30'h3FFF_FFFF;

  localparam logic [1:0] KIND_SEG    = 2'd0;
  localparam logic [1:0] KIND_CREDIT = 2'd1;
  localparam logic [1:0] KIND_INIT   = 2'd2;

  localparam logic [2:0] ST_IN_ORDER  = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_UNACCEPT  = 3'd2;
  localparam logic [2:0] ST_WIN_CLOSE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DUP       = 3'd5;
  localparam logic [2:0] ST_CTRL_DONE = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_INSERT,
    S_DRAIN,
    S_EMIT
  } core_state_t;

  // One transaction as handed from the front to the core.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [15:0] len;
    logic        fin;
    logic        push;
    logic        ctl;
    logic        reader;
    logic [29:0] wv;
    logic [16:0] seg_l;
    logic [31:0] seg_end;
  } item_t;

  function automatic logic ser_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic ser_le(logic [31:0] a, logic [31:0] b);
    return (a == b) || ser_lt(a, b);
  endfunction

endpackage

@@ hdl/tcp_receive_reassembly.sv @@
// TCP receive reassembly over segment descriptors.
// Input channel: drive the in_ fields and raise start; the transaction is
// taken at a rising edge where start is high and busy is low. The front
// holds one transaction in its queue register, so busy rises for as long as
// that slot is occupied and falls once the core has taken the transaction.
// Result channel: each result is shown for exactly one cycle with out_strobe
// high, and out_last marks the final result of a transaction. The receiver
// cannot stall; every strobe must be captured.
// Steps: the transaction waits in the queue register, the core takes it
// and classifies it; for an out-of-order segment the insertion walk then
// looks at stored entries from the tail toward the head, with a final step
// if it reaches the head, and the segment is inserted; head entries are
// drained until the store is empty or its head is not in order; then each
// result is emitted and passes through the output register.
// All results of a transaction are buffered until its work is done, since
// every result reports the final next expected number and window.
// Reset clears the next expected number, the window, the store count and
// the queue; store contents are not cleared and are never read unwritten.
module tcp_receive_reassembly import trr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_seg_seq,
  input  logic [15:0] in_seg_len,
  input  logic        in_flag_fin,
  input  logic        in_flag_push,
  input  logic        in_flag_control,
  input  logic        in_reader_has_data,
  input  logic [29:0] in_window_value,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic        out_span_valid,
  output logic [31:0] out_span_start,
  output logic [31:0] out_span_end,
  output logic        out_span_fin,
  output logic        out_wake,
  output logic        out_fin_reached,
  output logic [31:0] out_next_expected,
  output logic [29:0] out_window_left,
  output logic        out_last
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // The front takes transactions and precomputes the segment end.
  trr_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_seg_seq         (in_seg_seq),
    .in_seg_len         (in_seg_len),
    .in_flag_fin        (in_flag_fin),
    .in_flag_push       (in_flag_push),
    .in_flag_control    (in_flag_control),
    .in_reader_has_data (in_reader_has_data),
    .in_window_value    (in_window_value),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  // The core owns the sequence state and the sorted store, and emits results.
  trr_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_span_valid    (out_span_valid),
    .out_span_start    (out_span_start),
    .out_span_end      (out_span_end),
    .out_span_fin      (out_span_fin),
    .out_wake          (out_wake),
    .out_fin_reached   (out_fin_reached),
    .out_next_expected (out_next_expected),
    .out_window_left   (out_window_left),
    .out_last          (out_last)
  );

endmodule

@@ hdl/trr_front.sv @@
module trr_front import trr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_seg_seq,
  input  logic [15:0] in_seg_len,
  input  logic        in_flag_fin,
  input  logic        in_flag_push,
  input  logic        in_flag_control,
  input  logic        in_reader_has_data,
  input  logic [29:0] in_window_value,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  logic  q_valid_r, q_valid_nxt;
  item_t q_item_r, q_item_nxt;
  logic  accept;

  assign busy    = q_valid_r;
  assign accept  = start && !q_valid_r;
  assign q_valid = q_valid_r;
  assign q_item  = q_item_r;

  // The segment length counts the FIN as one sequence number.
  always_comb begin
    q_item_nxt = q_item_r;
    q_valid_nxt = q_valid_r;
    if (q_pop) begin
      q_valid_nxt = 1'b0;
    end
    if (accept) begin
      q_valid_nxt        = 1'b1;
      q_item_nxt.kind    = in_kind;
      q_item_nxt.seq     = in_seg_seq;
      q_item_nxt.len     = in_seg_len;
      q_item_nxt.fin     = in_flag_fin;
      q_item_nxt.push    = in_flag_push;
      q_item_nxt.ctl     = in_flag_control;
      q_item_nxt.reader  = in_reader_has_data;
      q_item_nxt.wv      = in_window_value;
      q_item_nxt.seg_l   = {1'b0, in_seg_len} + {16'd0, in_flag_fin};
      q_item_nxt.seg_end = in_seg_seq + {15'd0, {1'b0, in_seg_len} + {16'd0, in_flag_fin}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
    q_item_r <= q_item_nxt;
  end

endmodule

@@ hdl/trr_core.sv @@
module trr_core import trr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic        out_span_valid,
  output logic [31:0] out_span_start,
  output logic [31:0] out_span_end,
  output logic        out_span_fin,
  output logic        out_wake,
  output logic        out_fin_reached,
  output logic [31:0] out_next_expected,
  output logic [29:0] out_window_left,
  output logic        out_last
);

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] e;
    logic        fin;
    logic [31:0] ne;
    logic [29:0] win;
  } dlv_t;

  function automatic dlv_t deliver(logic [31:0] s, logic [31:0] e, logic f,
                                   logic [31:0] ne, logic [29:0] win);
    dlv_t        r;
    logic [31:0] lim;
    logic [31:0] used;
    lim   = ne + {2'b00, win};
    r.s   = ser_lt(s, ne) ? ne : s;
    r.e   = e;
    r.fin = f;
    if (ser_lt(lim, e)) begin
      r.e   = lim;
      r.fin = 1'b0;
    end
    used  = r.e - r.s;
    r.win = (used > {2'b00, win}) ? 30'd0 : win - used[29:0];
    r.ne  = r.e;
    return r;
  endfunction

  core_state_t state_r, state_nxt;
  item_t       it_r, it_nxt;
  logic [31:0] ne_r, ne_nxt;
  logic [29:0] win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] wm1;
  logic [IDX_W-1:0] widx;
  logic        wake_r, wake_nxt;
  logic        finr_r, finr_nxt;

  logic [31:0] st_start_r [STORE_DEPTH];
  logic [31:0] st_end_r   [STORE_DEPTH];
  logic        st_fin_r   [STORE_DEPTH];
  logic [31:0] st_start_nxt [STORE_DEPTH];
  logic [31:0] st_end_nxt   [STORE_DEPTH];
  logic        st_fin_nxt   [STORE_DEPTH];

  logic [2:0]  rb_status_r [RES_DEPTH];
  logic        rb_valid_r  [RES_DEPTH];
  logic [31:0] rb_start_r  [RES_DEPTH];
  logic [31:0] rb_end_r    [RES_DEPTH];
  logic        rb_fin_r    [RES_DEPTH];
  logic [2:0]  rb_status_nxt [RES_DEPTH];
  logic        rb_valid_nxt  [RES_DEPTH];
  logic [31:0] rb_start_nxt  [RES_DEPTH];
  logic [31:0] rb_end_nxt    [RES_DEPTH];
  logic        rb_fin_nxt    [RES_DEPTH];
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [RCNT_W-1:0] ei_r, ei_nxt;
  logic [RIDX_W-1:0] rwr;
  logic [RIDX_W-1:0] rrd;

  logic        o_strobe_r, o_strobe_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic        o_valid_r, o_valid_nxt;
  logic [31:0] o_start_r, o_start_nxt;
  logic [31:0] o_end_r, o_end_nxt;
  logic        o_fin_r, o_fin_nxt;
  logic        o_wake_r, o_wake_nxt;
  logic        o_finr_r, o_finr_nxt;
  logic [31:0] o_ne_r, o_ne_nxt;
  logic [29:0] o_win_r, o_win_nxt;
  logic        o_last_r, o_last_nxt;

  logic [31:0] seg_l32;
  logic [31:0] lim;
  logic        acc;
  logic        is_last;
  dlv_t        d;

  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign seg_l32 = {15'd0, it_r.seg_l};
  assign lim     = ne_r + {2'b00, win_r};
  assign wm1     = w_r - 1'b1;
  assign widx    = wm1[IDX_W-1:0];
  assign rwr     = rcnt_r[RIDX_W-1:0];
  assign rrd     = ei_r[RIDX_W-1:0];
  assign is_last = (ei_r == (rcnt_r - 1'b1));

  // Acceptability test of a segment against the current receive window.
  always_comb begin
    if (seg_l32 == 32'd0 && win_r == 30'd0) begin
      acc = it_r.ctl || (it_r.seq == ne_r);
    end else if (seg_l32 == 32'd0) begin
      acc = ser_le(ne_r, it_r.seq) && ser_lt(it_r.seq, lim);
    end else if (win_r == 30'd0) begin
      acc = 1'b0;
    end else begin
      acc = (ser_le(ne_r, it_r.seq) && ser_lt(it_r.seq, lim)) ||
            (ser_le(ne_r, it_r.seq + seg_l32 - 32'd1) &&
             ser_lt(it_r.seq + seg_l32 - 32'd1, lim));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    it_nxt        = it_r;
    ne_nxt        = ne_r;
    win_nxt       = win_r;
    cnt_nxt       = cnt_r;
    w_nxt         = w_r;
    pos_nxt       = pos_r;
    wake_nxt      = wake_r;
    finr_nxt      = finr_r;
    st_start_nxt  = st_start_r;
    st_end_nxt    = st_end_r;
    st_fin_nxt    = st_fin_r;
    rb_status_nxt = rb_status_r;
    rb_valid_nxt  = rb_valid_r;
    rb_start_nxt  = rb_start_r;
    rb_end_nxt    = rb_end_r;
    rb_fin_nxt    = rb_fin_r;
    rcnt_nxt      = rcnt_r;
    ei_nxt        = ei_r;
    o_strobe_nxt  = 1'b0;
    o_status_nxt  = o_status_r;
    o_valid_nxt   = o_valid_r;
    o_start_nxt   = o_start_r;
    o_end_nxt     = o_end_r;
    o_fin_nxt     = o_fin_r;
    o_wake_nxt    = o_wake_r;
    o_finr_nxt    = o_finr_r;
    o_ne_nxt      = o_ne_r;
    o_win_nxt     = o_win_r;
    o_last_nxt    = 1'b0;
    d             = deliver(it_r.seq, it_r.seg_end, it_r.fin, ne_r, win_r);

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          it_nxt    = q_item;
          rcnt_nxt  = '0;
          ei_nxt    = '0;
          wake_nxt  = 1'b0;
          finr_nxt  = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        rb_status_nxt[rwr] = ST_CTRL_DONE;
        rb_valid_nxt[rwr]  = 1'b0;
        rb_start_nxt[rwr]  = '0;
        rb_end_nxt[rwr]    = '0;
        rb_fin_nxt[rwr]    = 1'b0;
        rcnt_nxt           = rcnt_r + 1'b1;
        state_nxt          = S_EMIT;
        case (it_r.kind)
          KIND_CREDIT: begin
            win_nxt = ({1'b0, win_r} + {1'b0, it_r.wv} > {1'b0, WIN_MAX}) ?
                      WIN_MAX : win_r + it_r.wv;
          end
          KIND_INIT: begin
            ne_nxt  = it_r.seq;
            win_nxt = it_r.wv;
            cnt_nxt = '0;
          end
          KIND_SEG: begin
            if (!acc) begin
              rb_status_nxt[rwr] = ST_UNACCEPT;
            end else if (seg_l32 == 32'd0) begin
              rb_status_nxt[rwr] = ST_CTRL_DONE;
            end else if (win_r == 30'd0) begin
              rb_status_nxt[rwr] = ST_WIN_CLOSE;
            end else if (ser_le(it_r.seq, ne_r)) begin
              rb_status_nxt[rwr] = ST_IN_ORDER;
              rb_valid_nxt[rwr]  = 1'b1;
              rb_start_nxt[rwr]  = d.s;
              rb_end_nxt[rwr]    = d.e;
              rb_fin_nxt[rwr]    = d.fin;
              ne_nxt             = d.ne;
              win_nxt            = d.win;
              wake_nxt           = it_r.push || it_r.fin || it_r.reader;
              finr_nxt           = d.fin;
              state_nxt          = S_DRAIN;
            end else if (cnt_r >= CNT_W'(STORE_DEPTH)) begin
              rb_status_nxt[rwr] = ST_FULL;
            end else begin
              rcnt_nxt  = rcnt_r;
              w_nxt     = cnt_r;
              state_nxt = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      // Walk from the tail toward the head to find the slot sorted by end, or a duplicate.
      S_WALK: begin
        if (w_r == '0) begin
          pos_nxt   = '0;
          state_nxt = S_INSERT;
        end else if (ser_lt(st_end_r[widx], it_r.seg_end)) begin
          pos_nxt   = w_r;
          state_nxt = S_INSERT;
        end else if (ser_le(st_start_r[widx], it_r.seq)) begin
          rb_status_nxt[rwr] = ST_DUP;
          rb_valid_nxt[rwr]  = 1'b0;
          rb_start_nxt[rwr]  = '0;
          rb_end_nxt[rwr]    = '0;
          rb_fin_nxt[rwr]    = 1'b0;
          rcnt_nxt           = rcnt_r + 1'b1;
          state_nxt          = S_EMIT;
        end else begin
          w_nxt = wm1;
        end
      end

      S_INSERT: begin
        for (int j = 0; j < STORE_DEPTH; j++) begin
          if (CNT_W'(j) == pos_r) begin
            st_start_nxt[j] = it_r.seq;
            st_end_nxt[j]   = it_r.seg_end;
            st_fin_nxt[j]   = it_r.fin;
          end else if (CNT_W'(j) > pos_r) begin
            st_start_nxt[j] = st_start_r[(j > 0) ? j - 1 : 0];
            st_end_nxt[j]   = st_end_r[(j > 0) ? j - 1 : 0];
            st_fin_nxt[j]   = st_fin_r[(j > 0) ? j - 1 : 0];
          end
        end
        cnt_nxt            = cnt_r + 1'b1;
        rb_status_nxt[rwr] = ST_QUEUED;
        rb_valid_nxt[rwr]  = 1'b0;
        rb_start_nxt[rwr]  = '0;
        rb_end_nxt[rwr]    = '0;
        rb_fin_nxt[rwr]    = 1'b0;
        rcnt_nxt           = rcnt_r + 1'b1;
        state_nxt          = S_DRAIN;
      end

      // One head entry per cycle: discard stale ones, deliver in-order ones.
      S_DRAIN: begin
        d = deliver(st_start_r[0], st_end_r[0], st_fin_r[0], ne_r, win_r);
        if (cnt_r == '0 || ser_lt(ne_r, st_start_r[0]) &&
            !ser_le(st_end_r[0], ne_r)) begin
          if (win_r == 30'd0) begin
            wake_nxt = 1'b1;
          end
          state_nxt = S_EMIT;
        end else begin
          for (int j = 0; j < STORE_DEPTH - 1; j++) begin
            st_start_nxt[j] = st_start_r[j+1];
            st_end_nxt[j]   = st_end_r[j+1];
            st_fin_nxt[j]   = st_fin_r[j+1];
          end
          cnt_nxt = cnt_r - 1'b1;
          if (!ser_le(st_end_r[0], ne_r)) begin
            rb_status_nxt[rwr] = ST_IN_ORDER;
            rb_valid_nxt[rwr]  = 1'b1;
            rb_start_nxt[rwr]  = d.s;
            rb_end_nxt[rwr]    = d.e;
            rb_fin_nxt[rwr]    = d.fin;
            rcnt_nxt           = rcnt_r + 1'b1;
            ne_nxt             = d.ne;
            win_nxt            = d.win;
            wake_nxt           = 1'b1;
            if (d.fin) begin
              finr_nxt = 1'b1;
            end
          end
        end
      end

      S_EMIT: begin
        o_strobe_nxt = 1'b1;
        o_status_nxt = rb_status_r[rrd];
        o_valid_nxt  = rb_valid_r[rrd];
        o_start_nxt  = rb_start_r[rrd];
        o_end_nxt    = rb_end_r[rrd];
        o_fin_nxt    = rb_fin_r[rrd];
        o_wake_nxt   = is_last && wake_r;
        o_finr_nxt   = is_last && finr_r;
        o_ne_nxt     = ne_r;
        o_win_nxt    = win_r;
        o_last_nxt   = is_last;
        ei_nxt       = ei_r + 1'b1;
        if (is_last) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ne_r       <= '0;
      win_r      <= '0;
      cnt_r      <= '0;
      rcnt_r     <= '0;
      ei_r       <= '0;
      o_strobe_r <= 1'b0;
      o_last_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ne_r       <= ne_nxt;
      win_r      <= win_nxt;
      cnt_r      <= cnt_nxt;
      rcnt_r     <= rcnt_nxt;
      ei_r       <= ei_nxt;
      o_strobe_r <= o_strobe_nxt;
      o_last_r   <= o_last_nxt;
    end
    it_r        <= it_nxt;
    w_r         <= w_nxt;
    pos_r       <= pos_nxt;
    wake_r      <= wake_nxt;
    finr_r      <= finr_nxt;
    st_start_r  <= st_start_nxt;
    st_end_r    <= st_end_nxt;
    st_fin_r    <= st_fin_nxt;
    rb_status_r <= rb_status_nxt;
    rb_valid_r  <= rb_valid_nxt;
    rb_start_r  <= rb_start_nxt;
    rb_end_r    <= rb_end_nxt;
    rb_fin_r    <= rb_fin_nxt;
    o_status_r  <= o_status_nxt;
    o_valid_r   <= o_valid_nxt;
    o_start_r   <= o_start_nxt;
    o_end_r     <= o_end_nxt;
    o_fin_r     <= o_fin_nxt;
    o_wake_r    <= o_wake_nxt;
    o_finr_r    <= o_finr_nxt;
    o_ne_r      <= o_ne_nxt;
    o_win_r     <= o_win_nxt;
  end

  assign out_strobe        = o_strobe_r;
  assign out_status        = o_status_r;
  assign out_span_valid    = o_valid_r;
  assign out_span_start    = o_start_r;
  assign out_span_end      = o_end_r;
  assign out_span_fin      = o_fin_r;
  assign out_wake          = o_wake_r;
  assign out_fin_reached   = o_finr_r;
  assign out_next_expected = o_ne_r;
  assign out_window_left   = o_win_r;
  assign out_last          = o_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STORE_DEPTH))
    else $error("store count above depth");

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= RCNT_W'(RES_DEPTH))
    else $error("result buffer overflow");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    o_last_r |-> (state_r == S_IDLE) && o_strobe_r)
    else $error("last result while core still active");

  a_pop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_EXEC) && !o_strobe_r)
    else $error("pop did not start execution");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import trr_pkg::*;

  // Clock, reset and the block's ports.
  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [31:0] in_seg_seq;
  logic [15:0] in_seg_len;
  logic        in_flag_fin;
  logic        in_flag_push;
  logic        in_flag_control;
  logic        in_reader_has_data;
  logic [29:0] in_window_value;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic        out_span_valid;
  logic [31:0] out_span_start;
  logic [31:0] out_span_end;
  logic        out_span_fin;
  logic        out_wake;
  logic        out_fin_reached;
  logic [31:0] out_next_expected;
  logic [29:0] out_window_left;
  logic        out_last;

  tcp_receive_reassembly dut (.*);

  // One input transaction, one per port.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [15:0] len;
    logic        fin;
    logic        push;
    logic        ctl;
    logic        reader;
    logic [29:0] wv;
  } seg_desc_t;

  // One expected result transaction, laid out like the result ports.
  typedef struct {
    logic [2:0]  status;
    logic        span_valid;
    logic [31:0] span_start;
    logic [31:0] span_end;
    logic        span_fin;
    logic        wake;
    logic        fin_reached;
    logic [31:0] next_exp;
    logic [29:0] win_left;
    logic        last;
  } span_rec_t;

  // A directed row: the descriptor, plus an optional typed-in first result.
  typedef struct {
    seg_desc_t  d;
    bit         has_exp;
    span_rec_t  e;
  } dir_row_t;

  span_rec_t   pending_spans[$];
  int          err_count;
  int          items_sent;
  int          results_seen;
  int          spans_seen;
  int          queued_seen;

  // Predictor state: the receiver sequence space and the reorder store.
  logic [31:0] rcv_nxt;
  logic [29:0] rcv_wnd;
  logic [31:0] ooo_start[STORE_DEPTH];
  logic [31:0] ooo_end[STORE_DEPTH];
  logic        ooo_fin[STORE_DEPTH];
  int          ooo_count;

  // Results built up for the transaction being predicted.
  span_rec_t   step_out[$];

  // Clock: 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit sn_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic bit sn_le(logic [31:0] a, logic [31:0] b);
    return (a == b) || sn_lt(a, b);
  endfunction

  function automatic bit seq_in_window(logic [31:0] s);
    return sn_le(rcv_nxt, s) && sn_lt(s, rcv_nxt + 32'(rcv_wnd));
  endfunction

  // RFC 793 acceptability test on the effective length (FIN counted).
  function automatic bit seg_acceptable(logic [31:0] l, logic [31:0] s, logic ctl);
    if (l == 0 && rcv_wnd == 0) return ctl || s == rcv_nxt;
    if (l == 0) return seq_in_window(s);
    if (rcv_wnd == 0) return 1'b0;
    return seq_in_window(s) || seq_in_window(s + l - 32'd1);
  endfunction

  function automatic void push_result(logic [2:0] st, logic v, logic [31:0] s,
                                      logic [31:0] e, logic f);
    span_rec_t r;
    r = '{default: '0};
    r.status = st;
    r.span_valid = v;
    r.span_start = s;
    r.span_end = e;
    r.span_fin = f;
    step_out.push_back(r);
  endfunction

  // Clips a span to the next expected number and the window edge, then
  // advances the receiver. Returns whether the FIN survived the clipping.
  function automatic bit deliver_span(logic [31:0] s, logic [31:0] e, logic f);
    logic [31:0] edge_seq;
    logic [31:0] used;
    edge_seq = rcv_nxt + 32'(rcv_wnd);
    if (sn_lt(s, rcv_nxt)) s = rcv_nxt;
    if (sn_lt(edge_seq, e)) begin
      e = edge_seq;
      f = 1'b0;
    end
    used = e - s;
    rcv_wnd = (used > 32'(rcv_wnd)) ? 30'd0 : rcv_wnd - 30'(used);
    rcv_nxt = e;
    push_result(ST_IN_ORDER, 1'b1, s, e, f);
    return f;
  endfunction

  function automatic void drop_store_head();
    for (int i = 0; i + 1 < ooo_count; i++) begin
      ooo_start[i] = ooo_start[i + 1];
      ooo_end[i] = ooo_end[i + 1];
      ooo_fin[i] = ooo_fin[i + 1];
    end
    ooo_count--;
  endfunction

  // Predicts every result of one transaction and appends them to the
  // queue of pending spans, in the order the block must produce them.
  function automatic void predict_reassembly(seg_desc_t d);
    bit          wake_r;
    bit          fin_r;
    bit          drain;
    bit          dup;
    int          pos;
    logic [31:0] l;
    logic [31:0] seg_end;
    logic [30:0] sum;
    wake_r = 0;
    fin_r = 0;
    drain = 0;
    step_out.delete();
    if (d.kind == KIND_CREDIT) begin
      sum = 31'(rcv_wnd) + 31'(d.wv);
      rcv_wnd = (sum > 31'(WIN_MAX)) ? WIN_MAX : sum[29:0];
      push_result(ST_CTRL_DONE, 0, 0, 0, 0);
    end else if (d.kind == KIND_INIT) begin
      rcv_nxt = d.seq;
      rcv_wnd = d.wv;
      ooo_count = 0;
      push_result(ST_CTRL_DONE, 0, 0, 0, 0);
    end else if (d.kind != KIND_SEG) begin
      push_result(ST_CTRL_DONE, 0, 0, 0, 0);
    end else begin
      l = 32'(d.len) + (d.fin ? 32'd1 : 32'd0);
      seg_end = d.seq + l;
      if (!seg_acceptable(l, d.seq, d.ctl)) begin
        push_result(ST_UNACCEPT, 0, 0, 0, 0);
      end else if (l == 0) begin
        push_result(ST_CTRL_DONE, 0, 0, 0, 0);
      end else if (rcv_wnd == 0) begin
        push_result(ST_WIN_CLOSE, 0, 0, 0, 0);
      end else if (sn_le(d.seq, rcv_nxt)) begin
        if (d.push || d.fin || d.reader) wake_r = 1;
        if (deliver_span(d.seq, seg_end, d.fin)) fin_r = 1;
        drain = 1;
      end else if (ooo_count >= STORE_DEPTH) begin
        push_result(ST_FULL, 0, 0, 0, 0);
      end else begin
        pos = 0;
        dup = 0;
        for (int i = ooo_count - 1; i >= 0; i--) begin
          if (sn_lt(ooo_end[i], seg_end)) begin
            pos = i + 1;
            break;
          end
          if (sn_le(ooo_start[i], d.seq)) begin
            dup = 1;
            break;
          end
        end
        if (dup) begin
          push_result(ST_DUP, 0, 0, 0, 0);
        end else begin
          for (int i = ooo_count; i > pos; i--) begin
            ooo_start[i] = ooo_start[i - 1];
            ooo_end[i] = ooo_end[i - 1];
            ooo_fin[i] = ooo_fin[i - 1];
          end
          ooo_start[pos] = d.seq;
          ooo_end[pos] = seg_end;
          ooo_fin[pos] = d.fin;
          ooo_count++;
          push_result(ST_QUEUED, 0, 0, 0, 0);
          drain = 1;
        end
      end
      if (drain) begin
        // Discard stale heads, deliver heads that are now in order.
        while (ooo_count > 0) begin
          if (sn_le(ooo_end[0], rcv_nxt)) begin
            drop_store_head();
            continue;
          end
          if (sn_lt(rcv_nxt, ooo_start[0])) break;
          begin
            logic [31:0] hs;
            logic [31:0] he;
            logic        hf;
            hs = ooo_start[0];
            he = ooo_end[0];
            hf = ooo_fin[0];
            drop_store_head();
            wake_r = 1;
            if (deliver_span(hs, he, hf)) fin_r = 1;
          end
        end
        if (rcv_wnd == 0) wake_r = 1;
      end
    end
    // Final state and end-of-transaction flags go on every result.
    for (int i = 0; i < step_out.size(); i++) begin
      span_rec_t r;
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      r.wake = r.last && wake_r;
      r.fin_reached = r.last && fin_r;
      r.next_exp = rcv_nxt;
      r.win_left = rcv_wnd;
      pending_spans.push_back(r);
    end
  endfunction

  // Result monitor: every strobe is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      span_rec_t x;
      results_seen++;
      if (pending_spans.size() == 0) begin
        $error("unexpected result: status=%0d start=%0h", out_status, out_span_start);
        err_count++;
      end else begin
        x = pending_spans.pop_front();
        if (out_span_valid) spans_seen++;
        if (out_status == ST_QUEUED) queued_seen++;
        if (out_status !== x.status) begin
          $error("status: expected %0d, actual %0d", x.status, out_status);
          err_count++;
        end
        if (out_span_valid !== x.span_valid) begin
          $error("span_valid: expected %0d, actual %0d", x.span_valid, out_span_valid);
          err_count++;
        end
        if (out_span_start !== x.span_start) begin
          $error("span_start: expected %0h, actual %0h", x.span_start, out_span_start);
          err_count++;
        end
        if (out_span_end !== x.span_end) begin
          $error("span_end: expected %0h, actual %0h", x.span_end, out_span_end);
          err_count++;
        end
        if (out_span_fin !== x.span_fin) begin
          $error("span_fin: expected %0d, actual %0d", x.span_fin, out_span_fin);
          err_count++;
        end
        if (out_wake !== x.wake) begin
          $error("wake: expected %0d, actual %0d", x.wake, out_wake);
          err_count++;
        end
        if (out_fin_reached !== x.fin_reached) begin
          $error("fin_reached: expected %0d, actual %0d", x.fin_reached, out_fin_reached);
          err_count++;
        end
        if (out_next_expected !== x.next_exp) begin
          $error("next_expected: expected %0h, actual %0h", x.next_exp, out_next_expected);
          err_count++;
        end
        if (out_window_left !== x.win_left) begin
          $error("window_left: expected %0h, actual %0h", x.win_left, out_window_left);
          err_count++;
        end
        if (out_last !== x.last) begin
          $error("last: expected %0d, actual %0d", x.last, out_last);
          err_count++;
        end
      end
    end
  end

  // Whether the sender skips idling in front of the next transaction.
  bit quiet_phase;

  // Presents one transaction at the falling edge and holds it until the
  // block takes it. The expected results are predicted at acceptance, so a
  // typed-in first result (if any) is compared against the predictor too.
  // Start stays high after acceptance; the next call replaces the fields
  // or drops start while it idles.
  task automatic send_segment(seg_desc_t d, bit has_exp, span_rec_t e);
    if (!quiet_phase) begin
      while ($urandom_range(99) < 8) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    in_kind <= d.kind;
    in_seg_seq <= d.seq;
    in_seg_len <= d.len;
    in_flag_fin <= d.fin;
    in_flag_push <= d.push;
    in_flag_control <= d.ctl;
    in_reader_has_data <= d.reader;
    in_window_value <= d.wv;
    @(posedge clk);
    while (busy) @(posedge clk);
    begin
      int before_q;
      before_q = pending_spans.size();
      predict_reassembly(d);
      if (has_exp) begin
        span_rec_t p;
        p = pending_spans[before_q];
        if (p.status !== e.status || p.span_valid !== e.span_valid ||
            p.span_start !== e.span_start || p.span_end !== e.span_end ||
            p.next_exp !== e.next_exp || p.win_left !== e.win_left) begin
          $error("directed row %0d: table and predictor disagree", items_sent);
          err_count++;
        end
      end
    end
    items_sent++;
    @(negedge clk);
  endtask

  function automatic seg_desc_t mk_desc(logic [1:0] k, logic [31:0] s, logic [15:0] l,
                                        logic f, logic p, logic c, logic r,
                                        logic [29:0] w);
    seg_desc_t d;
    d.kind = k;
    d.seq = s;
    d.len = l;
    d.fin = f;
    d.push = p;
    d.ctl = c;
    d.reader = r;
    d.wv = w;
    return d;
  endfunction

  function automatic span_rec_t mk_exp(logic [2:0] st, logic v, logic [31:0] s,
                                       logic [31:0] e, logic [31:0] nx, logic [29:0] w);
    span_rec_t r;
    r = '{default: '0};
    r.status = st;
    r.span_valid = v;
    r.span_start = s;
    r.span_end = e;
    r.next_exp = nx;
    r.win_left = w;
    return r;
  endfunction

  // Random segment around the current receiver position; most land in or
  // just beyond the window so the store fills and drains.
  function automatic seg_desc_t rand_segment();
    seg_desc_t d;
    int        sel;
    d = mk_desc(KIND_SEG, 0, 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), 1'($urandom_range(1)), 30'($urandom));
    sel = $urandom_range(99);
    if (sel < 70) begin
      d.seq = rcv_nxt + $urandom_range(400) - 32'd40;
      d.len = 16'($urandom_range(120));
      d.fin = ($urandom_range(9) == 0);
    end else if (sel < 80) begin
      d.seq = $urandom;
      d.len = 16'($urandom);
    end else if (sel < 88) begin
      d.kind = KIND_CREDIT;
      d.wv = ($urandom_range(3) == 0) ? 30'($urandom) : 30'($urandom_range(300));
    end else if (sel < 94) begin
      d.kind = KIND_INIT;
      d.seq = ($urandom_range(1)) ? $urandom : 32'hFFFF_FF00 + $urandom_range(255);
      d.wv = $urandom_range(1) ? 30'($urandom_range(600)) : 30'($urandom);
    end else if (sel < 97) begin
      d.kind = 2'd3;
      d.seq = $urandom;
    end else begin
      d.seq = rcv_nxt + $urandom_range(3);
      d.len = 0;
      d.fin = 0;
    end
    return d;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    span_rec_t none;
    seg_desc_t d;
    none = '{default: '0};
    err_count = 0;
    items_sent = 0;
    results_seen = 0;
    spans_seen = 0;
    queued_seen = 0;
    rcv_nxt = '0;
    rcv_wnd = '0;
    ooo_count = 0;
    quiet_phase = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = '0;
    in_seg_seq = '0;
    in_seg_len = '0;
    in_flag_fin = 1'b0;
    in_flag_push = 1'b0;
    in_flag_control = 1'b0;
    in_reader_has_data = 1'b0;
    in_window_value = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. Rows with a typed-in result can be read straight off
    // the definition; the rest are checked by the predictor alone.
    // After reset the window is zero: a data segment is unacceptable, an
    // empty one at the next expected number is merely acknowledged.
    dir_rows.push_back('{mk_desc(KIND_SEG, 0, 10, 0, 0, 0, 0, 0), 1,
                         mk_exp(ST_UNACCEPT, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_desc(KIND_SEG, 0, 0, 0, 0, 0, 0, 0), 1,
                         mk_exp(ST_CTRL_DONE, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'h55, 0, 0, 0, 1, 0, 0), 1,
                         mk_exp(ST_CTRL_DONE, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_desc(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, 1, 1, WIN_MAX), 1,
                         mk_exp(ST_CTRL_DONE, 0, 0, 0, 0, 0)});
    // Credit saturates at the window limit.
    dir_rows.push_back('{mk_desc(KIND_CREDIT, 0, 0, 0, 0, 0, 0, WIN_MAX), 1,
                         mk_exp(ST_CTRL_DONE, 0, 0, 0, 0, WIN_MAX)});
    dir_rows.push_back('{mk_desc(KIND_CREDIT, 0, 0, 0, 0, 0, 0, 30'd5), 1,
                         mk_exp(ST_CTRL_DONE, 0, 0, 0, 0, WIN_MAX)});
    // Initialise just below the sequence wrap with a small window.
    dir_rows.push_back('{mk_desc(KIND_INIT, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 30'd100), 1,
                         mk_exp(ST_CTRL_DONE, 0, 0, 0, 32'hFFFF_FFF0, 30'd100)});
    // Out of order across the wrap, then a duplicate contained in it.
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'h0000_0010, 16'd20, 0, 0, 0, 0, 0), 1,
                         mk_exp(ST_QUEUED, 0, 0, 0, 32'hFFFF_FFF0, 30'd100)});
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'h0000_0012, 16'd5, 0, 0, 0, 0, 0), 1,
                         mk_exp(ST_DUP, 0, 0, 0, 32'hFFFF_FFF0, 30'd100)});
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'h0000_0008, 16'd4, 1, 0, 0, 0, 0), 0, none});
    // In-order with an overlapping head, then one more is queued; the store stays behind a gap.
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'hFFFF_FFEC, 16'd20, 0, 1, 0, 1, 0), 0, none});
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'h0000_000C, 16'd4, 0, 0, 0, 0, 0), 0, none});
    // A FIN segment whose tail runs past the window edge is queued; then one inside it is a duplicate.
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'h0000_0024, 16'hFFFF, 1, 0, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'h0000_0030, 16'd1, 0, 0, 0, 0, 0), 0, none});
    // Fill the store to its depth, then one more is refused.
    dir_rows.push_back('{mk_desc(KIND_INIT, 32'd1000, 0, 0, 0, 0, 0, 30'd4000), 1,
                         mk_exp(ST_CTRL_DONE, 0, 0, 0, 32'd1000, 30'd4000)});
    for (int i = 0; i < STORE_DEPTH; i++)
      dir_rows.push_back('{mk_desc(KIND_SEG, 32'd1100 + 32'(i) * 20, 16'd10, 0, 0, 0, 0, 0),
                           1, mk_exp(ST_QUEUED, 0, 0, 0, 32'd1000, 30'd4000)});
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'd2000, 16'd10, 0, 0, 0, 0, 0), 1,
                         mk_exp(ST_FULL, 0, 0, 0, 32'd1000, 30'd4000)});
    // Gap filler: drains one stored entry, the rest stay queued.
    dir_rows.push_back('{mk_desc(KIND_SEG, 32'd1000, 16'd100, 0, 0, 0, 0, 0), 0, none});

    foreach (dir_rows[i]) send_segment(dir_rows[i].d, dir_rows[i].has_exp, dir_rows[i].e);

    // Random part. A middle stretch runs with the sender never idling.
    for (int n = 0; n < 167; n++) begin
      quiet_phase = (n >= 60 && n < 110);
      d = rand_segment();
      send_segment(d, 0, none);
    end
    quiet_phase = 0;
    start <= 1'b0;

    // Wait for the last results, then give the block a short tail.
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d transactions: %0d results, %0d delivered spans, %0d queued.",
             items_sent, results_seen, spans_seen, queued_seen);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", pending_spans.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/trr_pkg.sv
hdl/trr_front.sv
hdl/trr_core.sv
hdl/tcp_receive_reassembly.sv
tb/tb.sv
